// File: rtl/core/nhr_pkg.sv
// shared types and constants for the ring all-gather step schedule unit
// no dependencies; used by every module under rtl/core
`default_nettype none

package nhr_pkg;

    localparam int MAX_RANKS  = 64;
    localparam int RANK_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int STEP_W     = 3;
    localparam int RESULT_CAP = 32;

    localparam logic [COUNT_W-1:0] RANK_COUNT_RST = COUNT_W'(8);
    localparam logic [RANK_W-1:0]  MY_RANK_RST    = '0;

    // configuration register indexes
    localparam logic CFG_RANK_COUNT = 1'b0;
    localparam logic CFG_MY_RANK    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       reduce;
        logic [2:0] red_bit;
        logic       calc;
        logic       advance;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/nhr_cfg.sv
// configuration registers: rank_count and my_rank
// depends on nhr_pkg
`default_nettype none

module nhr_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_index,
    input  wire logic [nhr_pkg::COUNT_W-1:0] cfg_data,
    output logic                             cfg_ready,
    output logic [nhr_pkg::COUNT_W-1:0]      rank_count,
    output logic [nhr_pkg::RANK_W-1:0]       my_rank
);

    logic [nhr_pkg::COUNT_W-1:0] rank_count_reg;
    logic [nhr_pkg::RANK_W-1:0]  my_rank_reg;

    assign cfg_ready  = 1'b1;
    assign rank_count = rank_count_reg;
    assign my_rank    = my_rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg <= nhr_pkg::RANK_COUNT_RST;
            my_rank_reg    <= nhr_pkg::MY_RANK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                nhr_pkg::CFG_RANK_COUNT: rank_count_reg <= cfg_data;
                nhr_pkg::CFG_MY_RANK:    my_rank_reg    <= cfg_data[nhr_pkg::RANK_W-1:0];
                default:                 rank_count_reg <= rank_count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/nhr_ctrl.sv
// sequencer: load, reduce my_rank modulo rank count, set up, emit slices
// depends on nhr_pkg
`default_nettype none

module nhr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire nhr_pkg::stat_t stat,
    output nhr_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                strobe
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETUP,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [2:0] bit_reg;
    logic       busy_reg;
    logic       strobe_reg;

    assign busy   = busy_reg;
    assign strobe = strobe_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == ST_IDLE) && start;
        cmd.reduce  = (state_reg == ST_REDUCE);
        cmd.red_bit = bit_reg;
        cmd.calc    = (state_reg == ST_SETUP);
        cmd.advance = (state_reg == ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bit_reg    <= '0;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_REDUCE;
                        bit_reg   <= 3'(nhr_pkg::RANK_W - 1);
                        busy_reg  <= 1'b1;
                    end
                end
                ST_REDUCE:
                begin
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    state_reg  <= ST_EMIT;
                    strobe_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (stat.last)
                    begin
                        state_reg  <= ST_IDLE;
                        strobe_reg <= 1'b0;
                        busy_reg   <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg  <= ST_IDLE;
                    strobe_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/nhr_dp.sv
// datapath: rank reduction, peer and count setup, slice index stepping
// depends on nhr_pkg
`default_nettype none

module nhr_dp (
    input  wire logic                        clk,
    input  wire nhr_pkg::cmd_t               cmd,
    input  wire logic [nhr_pkg::COUNT_W-1:0] rank_count,
    input  wire logic [nhr_pkg::RANK_W-1:0]  my_rank,
    input  wire logic [nhr_pkg::STEP_W-1:0]  step_index,
    output nhr_pkg::stat_t                   stat,
    output logic                             step_valid,
    output logic [nhr_pkg::STEP_W-1:0]       step_count,
    output logic [nhr_pkg::RANK_W-1:0]       send_peer,
    output logic [nhr_pkg::RANK_W-1:0]       receive_peer,
    output logic [nhr_pkg::RANK_W-1:0]       slice_count,
    output logic [nhr_pkg::RANK_W-1:0]       send_slice,
    output logic [nhr_pkg::RANK_W-1:0]       receive_slice,
    output logic                             last
);

    localparam int CW = nhr_pkg::COUNT_W;
    localparam int RW = nhr_pkg::RANK_W;
    localparam int SW = nhr_pkg::STEP_W;
    localparam int TW = CW + RW - 1;

    logic [CW-1:0]   n_reg;
    logic [RW-1:0]   rem_reg;
    logic [SW-1:0]   s_reg;
    logic            valid_reg;
    logic [SW-1:0]   steps_reg;
    logic [RW-1:0]   send_reg;
    logic [RW-1:0]   recv_reg;
    logic [RW-1:0]   cnt_reg;
    logic [CW-1:0]   dsm_reg;
    logic [RW-1:0]   tx_reg;
    logic [RW-1:0]   rx_reg;
    logic [RW-2:0]   idx_reg;

    logic [CW-1:0]   n_eff;
    logic [TW-1:0]   trial;
    logic [RW-1:0]   rem_next;
    logic [RW-1:0]   nm1;
    logic [SW-1:0]   steps;
    logic [SW-1:0]   sh;
    logic [CW-1:0]   dr;
    logic [CW-1:0]   ds;
    logic [CW:0]     send_sum;
    logic [CW:0]     recv_sum;
    logic [CW:0]     cnt_sum;
    logic [CW:0]     cnt_full;
    logic [RW-1:0]   send_next;
    logic [RW-1:0]   recv_next;
    logic [RW-1:0]   cnt_next;
    logic [CW-1:0]   dsm_next;
    logic [CW:0]     tx_sum;
    logic [CW:0]     rx_sum;
    logic [RW-1:0]   tx_next;
    logic [RW-1:0]   rx_next;
    logic [RW-1:0]   idx_inc;

    // zero counts as one rank, oversize saturates
    always_comb
    begin
        if (rank_count == '0)
            n_eff = CW'(1);
        else if (rank_count > CW'(nhr_pkg::MAX_RANKS))
            n_eff = CW'(nhr_pkg::MAX_RANKS);
        else
            n_eff = rank_count;
    end

    // one restoring step of my_rank mod n per cycle
    always_comb
    begin
        trial    = TW'(n_reg) << cmd.red_bit;
        rem_next = rem_reg;
        if (TW'(rem_reg) >= trial)
            rem_next = rem_reg - trial[RW-1:0];
    end

    // bit length of n - 1
    always_comb
    begin
        nm1   = RW'(n_reg - CW'(1));
        steps = '0;
        for (int i = 0; i < RW; i++)
        begin
            if (nm1[i])
                steps = SW'(i + 1);
        end
    end

    // all sums stay below twice n, so one conditional subtract reduces them
    always_comb
    begin
        sh       = steps - s_reg;
        dr       = CW'(1) << (sh - SW'(1));
        ds       = CW'(1) << sh;
        send_sum = (CW+1)'(rem_reg) + (CW+1)'(dr);
        recv_sum = (CW+1)'(rem_reg) + (CW+1)'(n_reg) - (CW+1)'(dr);
        send_next = (send_sum >= (CW+1)'(n_reg)) ? RW'(send_sum - (CW+1)'(n_reg))
                                                  : RW'(send_sum);
        recv_next = (recv_sum >= (CW+1)'(n_reg)) ? RW'(recv_sum - (CW+1)'(n_reg))
                                                  : RW'(recv_sum);
        cnt_sum  = (CW+1)'(n_reg) - (CW+1)'(1) + (CW+1)'(dr);
        cnt_full = cnt_sum >> sh;
        cnt_next = (cnt_full > (CW+1)'(nhr_pkg::RESULT_CAP)) ? RW'(nhr_pkg::RESULT_CAP)
                                                              : RW'(cnt_full);
        dsm_next = (ds >= n_reg) ? (ds - n_reg) : ds;
    end

    // step both slice indices back by the reduced slice delta
    always_comb
    begin
        tx_sum  = (CW+1)'(tx_reg) + (CW+1)'(n_reg) - (CW+1)'(dsm_reg);
        rx_sum  = (CW+1)'(rx_reg) + (CW+1)'(n_reg) - (CW+1)'(dsm_reg);
        tx_next = (tx_sum >= (CW+1)'(n_reg)) ? RW'(tx_sum - (CW+1)'(n_reg)) : RW'(tx_sum);
        rx_next = (rx_sum >= (CW+1)'(n_reg)) ? RW'(rx_sum - (CW+1)'(n_reg)) : RW'(rx_sum);
        idx_inc = RW'(idx_reg) + RW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= n_eff;
            rem_reg <= my_rank;
            s_reg   <= step_index;
        end
        if (cmd.reduce)
            rem_reg <= rem_next;
        if (cmd.calc)
        begin
            valid_reg <= (s_reg < steps);
            steps_reg <= steps;
            send_reg  <= send_next;
            recv_reg  <= recv_next;
            cnt_reg   <= cnt_next;
            dsm_reg   <= dsm_next;
            tx_reg    <= rem_reg;
            rx_reg    <= recv_next;
            idx_reg   <= '0;
        end
        if (cmd.advance)
        begin
            tx_reg  <= tx_next;
            rx_reg  <= rx_next;
            idx_reg <= idx_inc[RW-2:0];
        end
    end

    assign stat.last     = !valid_reg || (idx_inc == cnt_reg);
    assign last          = stat.last;
    assign step_valid    = valid_reg;
    assign step_count    = steps_reg;
    assign send_peer     = valid_reg ? send_reg : '0;
    assign receive_peer  = valid_reg ? recv_reg : '0;
    assign slice_count   = valid_reg ? cnt_reg  : '0;
    assign send_slice    = valid_reg ? tx_reg   : '0;
    assign receive_slice = valid_reg ? rx_reg   : '0;

endmodule

`default_nettype wire

// File: rtl/core/nhr_allgather_step_schedule_unit.sv
// top level of the ring all-gather step schedule unit
// depends on nhr_pkg, nhr_cfg, nhr_ctrl, nhr_dp
`default_nettype none

// A request is taken when start is high and busy is low. The unit reduces
// my_rank modulo the rank count (one restoring subtract per bit), then works
// out peers, slice count and slice step, then puts out one slice pair per
// cycle on strobe, with last on the final one. A step out of range gives a
// single word with last. Results cannot be held off; each is on the ports for
// exactly one strobe cycle. Configuration writes are always ready and must
// come only while busy is low.
module nhr_allgather_step_schedule_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [nhr_pkg::STEP_W-1:0]  step_index,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [nhr_pkg::COUNT_W-1:0] cfg_data,
    output logic                             strobe,
    output logic                             step_valid,
    output logic [nhr_pkg::STEP_W-1:0]       step_count,
    output logic [nhr_pkg::RANK_W-1:0]       send_peer,
    output logic [nhr_pkg::RANK_W-1:0]       receive_peer,
    output logic [nhr_pkg::RANK_W-1:0]       slice_count,
    output logic [nhr_pkg::RANK_W-1:0]       send_slice,
    output logic [nhr_pkg::RANK_W-1:0]       receive_slice,
    output logic                             last
);

    logic [nhr_pkg::COUNT_W-1:0] rank_count;
    logic [nhr_pkg::RANK_W-1:0]  my_rank;
    nhr_pkg::cmd_t               cmd;
    nhr_pkg::stat_t              stat;

    nhr_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .rank_count (rank_count),
        .my_rank    (my_rank)
    );

    nhr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    nhr_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .rank_count    (rank_count),
        .my_rank       (my_rank),
        .step_index    (step_index),
        .stat          (stat),
        .step_valid    (step_valid),
        .step_count    (step_count),
        .send_peer     (send_peer),
        .receive_peer  (receive_peer),
        .slice_count   (slice_count),
        .send_slice    (send_slice),
        .receive_slice (receive_slice),
        .last          (last)
    );

    // a word only appears while a request is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("strobe outside a busy request");

    // the final word closes the request
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe && !busy)
        else $error("words continue after last");

    // an out-of-range step gives exactly one word
    a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !step_valid |-> last)
        else $error("invalid step without last");

    // an accepted request cannot produce a word on the next cycle
    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !strobe)
        else $error("request not registered as busy");

endmodule

`default_nettype wire
